FILE: design/cst_pkg.sv
// Shared widths, constants and beat types for the triangle stiffness pipeline.
`default_nettype none
package cst_pkg;

    localparam int CW    = 33;   // coordinate difference
    localparam int PW    = 66;   // product of two differences
    localparam int DETW  = 67;   // signed determinant
    localparam int DMAGW = 66;   // determinant magnitude
    localparam int HALF  = 33;   // split point of the determinant magnitude
    localparam int QCW   = 33;   // 2^32 - p^2
    localparam int DMW   = 98;   // divisor magnitude
    localparam int RW    = 99;   // partial remainder
    localparam int KW    = 18;   // material coefficient
    localparam int NW    = 84;   // signed numerator
    localparam int MAGW  = 83;   // numerator magnitude
    localparam int SPLIT = 42;   // split point of the numerator magnitude
    localparam int MW    = 115;  // numerator times modulus
    localparam int MLOW  = 18;   // dividend bits fed into the long division
    localparam int QW    = 48;   // quotient bits
    localparam int VW    = 48;   // result value
    localparam int EW    = 32;
    localparam int PRW   = 15;
    localparam int NODEW = 10;
    localparam int IDXW  = 11;

    localparam logic [EW-1:0]  YOUNG_RESET   = 32'd1;
    localparam logic [PRW-1:0] POISSON_RESET = 15'd19661;
    localparam logic [KW-1:0]  COEF_UNIT     = 18'h20000;
    localparam logic [KW-1:0]  COEF_SHEAR    = 18'h10000;
    localparam logic [QCW-1:0] DEN_BASE      = 33'h1_0000_0000;
    localparam logic [QW:0]    LIMIT         = 49'h0_8000_0000_0000;
    localparam logic [VW-1:0]  VAL_MAX       = 48'h7FFF_FFFF_FFFF;
    localparam logic [VW-1:0]  VAL_MIN       = 48'h8000_0000_0000;

    typedef enum logic {
        REG_YOUNG   = 1'b0,
        REG_POISSON = 1'b1
    } t_reg;

    typedef struct packed {
        logic [2:0][CW-1:0]    b;
        logic [2:0][CW-1:0]    c;
        logic [DMW-1:0]        dm;
        logic                  dneg;
        logic                  degen;
        logic [2:0][NODEW-1:0] node;
    } t_tri;

    typedef struct packed {
        logic [DMW-1:0]  dm;
        logic            dneg;
        logic            degen;
        logic [IDXW-1:0] row;
        logic [IDXW-1:0] col;
        logic            last;
    } t_side;

    typedef struct packed {
        logic [CW-1:0] u1;
        logic [CW-1:0] v1;
        logic [CW-1:0] u2;
        logic [CW-1:0] v2;
        logic          unit_a;
        t_side         side;
    } t_ent;

    typedef struct packed {
        t_side           side;
        logic [RW-1:0]   r;
        logic [QW-1:0]   q;
        logic [MLOW-1:0] mlo;
        logic            neg;
        logic            sat;
    } t_div;

endpackage
`default_nettype wire

FILE: design/cst_geom.sv
// Per-triangle front end: edge vectors, determinant and divisor.
`default_nettype none
module cst_geom (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [31:0]             i_x_first,
    input  logic signed [31:0]             i_y_first,
    input  logic signed [31:0]             i_x_second,
    input  logic signed [31:0]             i_y_second,
    input  logic signed [31:0]             i_x_third,
    input  logic signed [31:0]             i_y_third,
    input  logic [cst_pkg::NODEW-1:0]      i_node_first,
    input  logic [cst_pkg::NODEW-1:0]      i_node_second,
    input  logic [cst_pkg::NODEW-1:0]      i_node_third,
    input  logic [cst_pkg::QCW-1:0]        i_den_scale,
    input  logic                           i_take,
    output logic                           o_ready,
    output logic                           o_valid,
    output cst_pkg::t_tri                  o_tri
);

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic ld1, ld2, ld3, ld4, ld5;

    logic signed [cst_pkg::CW-1:0]   r1_dx1, r1_dy2, r1_dx2, r1_dy1;
    cst_pkg::t_tri                   r1_tri, r2_tri, r3_tri, r4_tri, r5_tri;
    cst_pkg::t_tri                   n_tri1, n_tri3, n_tri5;
    logic signed [cst_pkg::PW-1:0]   r2_pa, r2_pb;
    logic signed [cst_pkg::DETW-1:0] n_det;
    logic [cst_pkg::DMAGW-1:0]       n_mag, r3_mag;
    logic [cst_pkg::PW-1:0]          r4_lo, r4_hi;
    logic [cst_pkg::DMW-1:0]         n_dm;

    assign ld5 = !r_v5 || i_take;
    assign ld4 = !r_v4 || ld5;
    assign ld3 = !r_v3 || ld4;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;
    assign o_ready = ld1;
    assign o_valid = r_v5;
    assign o_tri   = r5_tri;

    always_comb begin
        n_tri1      = '0;
        n_tri1.b[0] = cst_pkg::CW'(i_y_second) - cst_pkg::CW'(i_y_third);
        n_tri1.b[1] = cst_pkg::CW'(i_y_third)  - cst_pkg::CW'(i_y_first);
        n_tri1.b[2] = cst_pkg::CW'(i_y_first)  - cst_pkg::CW'(i_y_second);
        n_tri1.c[0] = cst_pkg::CW'(i_x_third)  - cst_pkg::CW'(i_x_second);
        n_tri1.c[1] = cst_pkg::CW'(i_x_first)  - cst_pkg::CW'(i_x_third);
        n_tri1.c[2] = cst_pkg::CW'(i_x_second) - cst_pkg::CW'(i_x_first);
        n_tri1.node = {i_node_third, i_node_second, i_node_first};
    end

    assign n_det = cst_pkg::DETW'(r2_pa) - cst_pkg::DETW'(r2_pb);
    assign n_mag = n_det[cst_pkg::DETW-1] ? cst_pkg::DMAGW'(-n_det) : cst_pkg::DMAGW'(n_det);
    assign n_dm  = cst_pkg::DMW'({{cst_pkg::HALF{1'b0}}, r4_lo})
                 + cst_pkg::DMW'({r4_hi, {cst_pkg::HALF{1'b0}}});

    always_comb begin
        n_tri3       = r2_tri;
        n_tri3.dneg  = n_det[cst_pkg::DETW-1];
        n_tri3.degen = (n_det == '0);
    end

    always_comb begin
        n_tri5    = r4_tri;
        n_tri5.dm = n_dm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (ld1) r_v1 <= i_valid;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
            if (ld4) r_v4 <= r_v3;
            if (ld5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r1_dx1 <= cst_pkg::CW'(i_x_second) - cst_pkg::CW'(i_x_first);
            r1_dy2 <= cst_pkg::CW'(i_y_third)  - cst_pkg::CW'(i_y_first);
            r1_dx2 <= cst_pkg::CW'(i_x_third)  - cst_pkg::CW'(i_x_first);
            r1_dy1 <= cst_pkg::CW'(i_y_second) - cst_pkg::CW'(i_y_first);
            r1_tri <= n_tri1;
        end
        if (ld2) begin
            r2_pa  <= r1_dx1 * r1_dy2;
            r2_pb  <= r1_dx2 * r1_dy1;
            r2_tri <= r1_tri;
        end
        if (ld3) begin
            r3_mag <= n_mag;
            r3_tri <= n_tri3;
        end
        if (ld4) begin
            r4_lo  <= i_den_scale * r3_mag[cst_pkg::HALF-1:0];
            r4_hi  <= i_den_scale * r3_mag[cst_pkg::DMAGW-1:cst_pkg::HALF];
            r4_tri <= r3_tri;
        end
        if (ld5) begin
            r5_tri <= n_tri5;
        end
    end

endmodule
`default_nettype wire

FILE: design/cst_seq.sv
// Entry sequencer: walks the 36 row/column/dof combinations of one triangle.
`default_nettype none
module cst_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tri_valid,
    input  cst_pkg::t_tri i_tri,
    input  logic          i_adv,
    output logic          o_take,
    output logic          o_valid,
    output cst_pkg::t_ent o_ent
);

    cst_pkg::t_tri r_tri;
    logic          r_busy;
    logic [1:0]    r_i, r_j, r_d;
    logic          r_ev;
    cst_pkg::t_ent r_ent, n_ent;
    logic          fire, last;

    assign fire   = r_busy && i_adv;
    assign last   = (r_i == 2'd2) && (r_j == 2'd2) && (r_d == 2'd3);
    assign o_take = i_tri_valid && (!r_busy || (fire && last));
    assign o_valid = r_ev;
    assign o_ent   = r_ent;

    always_comb begin
        n_ent            = '0;
        n_ent.u1         = r_d[1] ? r_tri.c[r_i] : r_tri.b[r_i];
        n_ent.v1         = r_d[0] ? r_tri.c[r_j] : r_tri.b[r_j];
        n_ent.u2         = r_d[1] ? r_tri.b[r_i] : r_tri.c[r_i];
        n_ent.v2         = r_d[0] ? r_tri.b[r_j] : r_tri.c[r_j];
        n_ent.unit_a     = (r_d[1] == r_d[0]);
        n_ent.side.dm    = r_tri.dm;
        n_ent.side.dneg  = r_tri.dneg;
        n_ent.side.degen = r_tri.degen;
        n_ent.side.row   = {r_tri.node[r_i], r_d[1]};
        n_ent.side.col   = {r_tri.node[r_j], r_d[0]};
        n_ent.side.last  = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= 2'd0;
            r_j    <= 2'd0;
            r_d    <= 2'd0;
            r_ev   <= 1'b0;
        end else begin
            if (i_adv) r_ev <= fire;
            if (o_take) begin
                r_busy <= 1'b1;
                r_i    <= 2'd0;
                r_j    <= 2'd0;
                r_d    <= 2'd0;
            end else if (fire && last) begin
                r_busy <= 1'b0;
            end else if (fire) begin
                r_d <= r_d + 2'd1;
                if (r_d == 2'd3) begin
                    if (r_j == 2'd2) begin
                        r_j <= 2'd0;
                        r_i <= r_i + 2'd1;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) r_tri <= i_tri;
        if (i_adv) r_ent <= n_ent;
    end

`ifndef SYNTHESIS
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_i != 2'd3) && (r_j != 2'd3))
        else $error("entry index out of range");
`endif

endmodule
`default_nettype wire

FILE: design/cst_entry.sv
// Numerator datapath: products, material weighting, magnitude, modulus scaling.
`default_nettype none
module cst_entry (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_valid,
    input  cst_pkg::t_ent             i_ent,
    input  logic [cst_pkg::EW-1:0]    i_young,
    input  logic [cst_pkg::PRW-1:0]   i_poisson,
    output logic                      o_valid,
    output cst_pkg::t_div             o_div
);

    logic [6:0] r_v;

    cst_pkg::t_side                    r2_s, r3_s, r4_s, r5_s, r6_s, r7_s;
    logic signed [cst_pkg::PW-1:0]     r2_p1, r2_p2;
    logic [cst_pkg::KW-1:0]            r2_a, r2_b;
    logic signed [cst_pkg::NW-1:0]     r3_t1, r3_t2, r4_n, n_abs;
    logic [cst_pkg::MAGW-1:0]          r5_mag;
    logic                              r5_neg, r6_neg, r7_neg;
    logic [cst_pkg::SPLIT+cst_pkg::EW-1:0]                r6_lo;
    logic [cst_pkg::MAGW-cst_pkg::SPLIT+cst_pkg::EW-1:0]  r6_hi;
    logic [cst_pkg::MW-1:0]            r7_m, n_m;
    logic [cst_pkg::RW-1:0]            n_r0;
    cst_pkg::t_div                     r8_d;

    assign o_valid = r_v[6];
    assign o_div   = r8_d;

    assign n_abs = r4_n[cst_pkg::NW-1] ? -r4_n : r4_n;
    assign n_m   = cst_pkg::MW'(r6_lo) + (cst_pkg::MW'(r6_hi) << cst_pkg::SPLIT);
    assign n_r0  = cst_pkg::RW'(r7_m[cst_pkg::MW-1:cst_pkg::MLOW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (i_adv) r_v <= {r_v[5:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_p1 <= $signed(i_ent.u1) * $signed(i_ent.v1);
            r2_p2 <= $signed(i_ent.u2) * $signed(i_ent.v2);
            r2_a  <= i_ent.unit_a ? cst_pkg::COEF_UNIT : {2'b00, i_poisson, 1'b0};
            r2_b  <= cst_pkg::COEF_SHEAR - {3'b000, i_poisson};
            r2_s  <= i_ent.side;

            r3_t1 <= r2_p1 * $signed({1'b0, r2_a});
            r3_t2 <= r2_p2 * $signed({1'b0, r2_b});
            r3_s  <= r2_s;

            r4_n <= r3_t1 + r3_t2;
            r4_s <= r3_s;

            r5_mag <= n_abs[cst_pkg::MAGW-1:0];
            r5_neg <= r4_n[cst_pkg::NW-1] ^ r4_s.dneg;
            r5_s   <= r4_s;

            r6_lo  <= r5_mag[cst_pkg::SPLIT-1:0] * i_young;
            r6_hi  <= r5_mag[cst_pkg::MAGW-1:cst_pkg::SPLIT] * i_young;
            r6_neg <= r5_neg;
            r6_s   <= r5_s;

            r7_m   <= n_m;
            r7_neg <= r6_neg;
            r7_s   <= r6_s;

            r8_d.side <= r7_s;
            r8_d.r    <= n_r0;
            r8_d.q    <= '0;
            r8_d.mlo  <= r7_m[cst_pkg::MLOW-1:0];
            r8_d.neg  <= r7_neg;
            r8_d.sat  <= n_r0 >= {1'b0, r7_s.dm};
        end
    end

endmodule
`default_nettype wire

FILE: design/cst_divider.sv
// Pipelined restoring divider with rounding, saturation and result register.
`default_nettype none
module cst_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  cst_pkg::t_div               i_div,
    output logic                        o_valid,
    output logic [cst_pkg::IDXW-1:0]    o_row,
    output logic [cst_pkg::IDXW-1:0]    o_col,
    output logic signed [cst_pkg::VW-1:0] o_value,
    output logic                        o_degen,
    output logic                        o_last
);

    cst_pkg::t_div          w_in [cst_pkg::QW];
    cst_pkg::t_div          r_st [cst_pkg::QW];
    logic [cst_pkg::QW-1:0] r_sv;

    logic                   r_rv, r_ov;
    logic [cst_pkg::QW:0]   r_rq;
    logic                   r_rneg, r_rsat;
    cst_pkg::t_side         r_rs;
    logic                   n_rnd;
    logic [cst_pkg::VW-1:0] n_val;
    cst_pkg::t_div          w_last;

    for (genvar s = 0; s < cst_pkg::QW; s++) begin : g_stage
        logic [cst_pkg::RW-1:0] w_trial;
        logic                   w_ge;
        cst_pkg::t_div          n_st;
        if (s == 0) begin : g_first
            assign w_in[s] = i_div;
        end else begin : g_next
            assign w_in[s] = r_st[s-1];
        end
        assign w_trial = {w_in[s].r[cst_pkg::RW-2:0], w_in[s].mlo[cst_pkg::MLOW-1]};
        assign w_ge    = w_trial >= {1'b0, w_in[s].side.dm};
        always_comb begin
            n_st     = w_in[s];
            n_st.r   = w_ge ? w_trial - {1'b0, w_in[s].side.dm} : w_trial;
            n_st.q   = {w_in[s].q[cst_pkg::QW-2:0], w_ge};
            n_st.mlo = w_in[s].mlo << 1;
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_st[s] <= n_st;
            end
        end
    end

    assign w_last = r_st[cst_pkg::QW-1];
    assign n_rnd  = {w_last.r, 1'b0} >= {2'b00, w_last.side.dm};

    always_comb begin
        if (r_rs.degen) begin
            n_val = '0;
        end else if (r_rsat) begin
            n_val = r_rneg ? cst_pkg::VAL_MIN : cst_pkg::VAL_MAX;
        end else if (r_rneg) begin
            n_val = (r_rq > cst_pkg::LIMIT) ? cst_pkg::VAL_MIN
                                            : cst_pkg::VW'({(cst_pkg::QW+1){1'b0}} - r_rq);
        end else begin
            n_val = (r_rq >= cst_pkg::LIMIT) ? cst_pkg::VAL_MAX : r_rq[cst_pkg::VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
            r_rv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_adv) begin
            r_sv <= {r_sv[cst_pkg::QW-2:0], i_valid};
            r_rv <= r_sv[cst_pkg::QW-1];
            r_ov <= r_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rq    <= {1'b0, w_last.q} + {{cst_pkg::QW{1'b0}}, n_rnd};
            r_rneg  <= w_last.neg;
            r_rsat  <= w_last.sat;
            r_rs    <= w_last.side;
            o_value <= n_val;
            o_row   <= r_rs.row;
            o_col   <= r_rs.col;
            o_degen <= r_rs.degen;
            o_last  <= r_rs.last;
        end
    end

    assign o_valid = r_ov;

endmodule
`default_nettype wire

FILE: design/triangle_element_stiffness_top.sv
// Top level: register port, triangle front end, entry pipeline and divider.
// Constant-strain triangle stiffness, plane stress. A triangle beat is taken
// when the sequencer is idle or issues the last entry of the one before; its
// 36 (row, column, value) triplets leave one per cycle while not stalled, in
// row-vertex, column-vertex, (x,x) (x,y) (y,x) (y,y) order. The single entry
// datapath, one triplet per clock when not stalled, sets the rate. A triangle
// beat passes an input register, four further geometry stages, a load and an
// issue stage in the sequencer, seven numerator stages, a 48-stage divider, a
// rounding stage and the output register. Back-pressure stalls the whole entry
// pipeline in place. Values are signed Q31.16, rounded to nearest with ties
// away from zero, saturated; a zero determinant flags degenerate and gives
// zero values. Registers: 0x0 Young's modulus, 0x4 Poisson ratio (Q0.16);
// write only while the block is idle.
`default_nettype none
module triangle_element_stiffness_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [31:0]            i_x_first,
    input  logic signed [31:0]            i_y_first,
    input  logic signed [31:0]            i_x_second,
    input  logic signed [31:0]            i_y_second,
    input  logic signed [31:0]            i_x_third,
    input  logic signed [31:0]            i_y_third,
    input  logic [9:0]                    i_node_first,
    input  logic [9:0]                    i_node_second,
    input  logic [9:0]                    i_node_third,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [10:0]                   o_entry_row,
    output logic [10:0]                   o_entry_column,
    output logic signed [47:0]            o_entry_value,
    output logic                          o_degenerate,
    output logic                          o_last_entry
);

    logic [cst_pkg::EW-1:0]  r_young;
    logic [cst_pkg::PRW-1:0] r_poisson;
    logic [cst_pkg::QCW-1:0] r_den_scale;
    logic [2*cst_pkg::PRW-1:0] n_psq;
    logic                    cfg_wr;
    logic                    adv;

    logic          tri_valid, tri_take, ent_valid, div_valid;
    cst_pkg::t_tri tri_data;
    cst_pkg::t_ent ent_data;
    cst_pkg::t_div div_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (cst_pkg::t_reg'(paddr[2]) == cst_pkg::REG_POISSON)
                  ? {17'd0, r_poisson} : r_young;
    assign n_psq  = r_poisson * r_poisson;
    assign adv    = !o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_young   <= cst_pkg::YOUNG_RESET;
            r_poisson <= cst_pkg::POISSON_RESET;
        end else if (cfg_wr) begin
            unique case (cst_pkg::t_reg'(paddr[2]))
                cst_pkg::REG_YOUNG:   r_young   <= pwdata;
                cst_pkg::REG_POISSON: r_poisson <= pwdata[cst_pkg::PRW-1:0];
                default:              r_young   <= r_young;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_den_scale <= cst_pkg::DEN_BASE - {3'b000, n_psq};
    end

    cst_geom u_geom (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_x_first    (i_x_first),
        .i_y_first    (i_y_first),
        .i_x_second   (i_x_second),
        .i_y_second   (i_y_second),
        .i_x_third    (i_x_third),
        .i_y_third    (i_y_third),
        .i_node_first (i_node_first),
        .i_node_second(i_node_second),
        .i_node_third (i_node_third),
        .i_den_scale  (r_den_scale),
        .i_take       (tri_take),
        .o_ready      (o_ready),
        .o_valid      (tri_valid),
        .o_tri        (tri_data)
    );

    cst_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tri_valid(tri_valid),
        .i_tri      (tri_data),
        .i_adv      (adv),
        .o_take     (tri_take),
        .o_valid    (ent_valid),
        .o_ent      (ent_data)
    );

    cst_entry u_entry (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (ent_valid),
        .i_ent    (ent_data),
        .i_young  (r_young),
        .i_poisson(r_poisson),
        .o_valid  (div_valid),
        .o_div    (div_data)
    );

    cst_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (adv),
        .i_valid(div_valid),
        .i_div  (div_data),
        .o_valid(o_valid),
        .o_row  (o_entry_row),
        .o_col  (o_entry_column),
        .o_value(o_entry_value),
        .o_degen(o_degenerate),
        .o_last (o_last_entry)
    );

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_entry_value == '0)
        else $error("degenerate beat with nonzero value");

    a_last_is_yy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_entry |-> o_entry_row[0] && o_entry_column[0])
        else $error("last beat is not the (y,y) entry");

    a_poisson_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && cfg_wr && paddr[2] |=> r_poisson == $past(pwdata[cst_pkg::PRW-1:0]))
        else $error("Poisson ratio write lost");
`endif

endmodule
`default_nettype wire
